// File: hdl/aged_request_tracker_assert.svh
// assertion macros shared by the aged request tracker rtl
`ifndef AGED_REQUEST_TRACKER_ASSERT_SVH
`define AGED_REQUEST_TRACKER_ASSERT_SVH

// expression holds on every clock out of reset
`define ART_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ART_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ART_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/art_pkg.sv
// types and constants of the aged request tracker
`timescale 1ns / 1ps
`default_nettype none

package art_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FILL_W   = 6;
    localparam int AGE_W    = 8;
    localparam int WORD_W   = 32;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = AGE_W'(10);

    // request kinds
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // one request as taken in at start
    typedef struct packed {
        logic              req_type;
        logic [WORD_W-1:0] client_address;
        logic [WORD_W-1:0] server_address;
        logic [WORD_W-1:0] track_key;
        logic [WORD_W-1:0] now_seconds;
    } req_t;

    // one stored table entry
    typedef struct packed {
        logic [WORD_W-1:0] client;
        logic [WORD_W-1:0] server;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] stamp;
    } entry_t;

    // result of one request
    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] found_track_key;
        logic              dropped;
        logic [FILL_W-1:0] fill_level;
    } res_t;

endpackage

`default_nettype wire

// File: hdl/art_engine.sv
// table memory and sequencer for eviction, append and newest-match lookup
`timescale 1ns / 1ps
`default_nettype none
`include "aged_request_tracker_assert.svh"

module art_engine
    import art_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire req_t             req,
    input  wire logic [AGE_W-1:0] age_limit,
    output logic                  busy,
    output logic                  done,
    output res_t                  res
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RREAD  = 3'd1;
    localparam logic [2:0] ST_RCHECK = 3'd2;
    localparam logic [2:0] ST_RMOVE  = 3'd3;
    localparam logic [2:0] ST_APPEND = 3'd4;
    localparam logic [2:0] ST_LSCAN  = 3'd5;

    logic [2:0]        state_reg,   state_next;
    logic [CNT_W-1:0]  idx_reg,     idx_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    req_t              req_reg,     req_next;
    logic [WORD_W-1:0] best_reg,    best_next;
    logic              found_reg,   found_next;
    logic [WORD_W-1:0] fkey_reg,    fkey_next;
    logic              dropped_reg, dropped_next;
    logic              chk_reg,     chk_next;
    logic              done_reg,    done_next;

    // table memory
    entry_t            mem [CAPACITY];
    entry_t            rd_data_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    logic [WORD_W-1:0] age;
    logic [CNT_W-1:0]  last;
    logic              match;

    assign age   = req_reg.now_seconds - rd_data_reg.stamp;
    assign last  = count_reg - CNT_W'(1);
    assign match = (rd_data_reg.client == req_reg.client_address) &&
                   (rd_data_reg.server == req_reg.server_address) &&
                   (rd_data_reg.stamp > best_reg);

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        req_next     = req_reg;
        best_next    = best_reg;
        found_next   = found_reg;
        fkey_next    = fkey_reg;
        dropped_next = dropped_reg;
        chk_next     = 1'b0;
        done_next    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = idx_reg[IDX_W-1:0];
        wr_data      = rd_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next     = req;
                    idx_next     = '0;
                    best_next    = '0;
                    found_next   = 1'b0;
                    fkey_next    = '0;
                    dropped_next = 1'b0;
                    state_next   = (req.req_type == REQ_LOOKUP) ? ST_LSCAN : ST_RREAD;
                end
            end
            ST_RREAD:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_RCHECK;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_RCHECK:
            begin
                if (age > WORD_W'(age_limit))
                begin
                    // evict: pull the last entry into this slot and check it again
                    count_next = last;
                    if (idx_reg < last)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = last[IDX_W-1:0];
                        state_next = ST_RMOVE;
                    end
                    else
                    begin
                        state_next = ST_RREAD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_RREAD;
                end
            end
            ST_RMOVE:
            begin
                wr_en      = 1'b1;
                state_next = ST_RREAD;
            end
            ST_APPEND:
            begin
                if (count_reg < CNT_W'(CAPACITY))
                begin
                    wr_en         = 1'b1;
                    wr_addr       = count_reg[IDX_W-1:0];
                    wr_data.client = req_reg.client_address;
                    wr_data.server = req_reg.server_address;
                    wr_data.key    = req_reg.track_key;
                    wr_data.stamp  = req_reg.now_seconds;
                    count_next    = count_reg + CNT_W'(1);
                end
                else
                begin
                    dropped_next = 1'b1;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_LSCAN:
            begin
                // issue one read per cycle, compare the previous read
                if (idx_reg < count_reg)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                    chk_next = 1'b1;
                end
                if (chk_reg && match)
                begin
                    best_next  = rd_data_reg.stamp;
                    found_next = 1'b1;
                    fkey_next  = rd_data_reg.key;
                end
                if (!(idx_reg < count_reg) && !chk_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            chk_reg     <= 1'b0;
            done_reg    <= 1'b0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chk_reg     <= chk_next;
            done_reg    <= done_next;
            idx_reg     <= idx_next;
            found_reg   <= found_next;
            dropped_reg <= dropped_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        best_reg <= best_next;
        fkey_reg <= fkey_next;
    end

    // table memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign busy                = (state_reg != ST_IDLE);
    assign done                = done_reg;
    assign res.found           = found_reg;
    assign res.found_track_key = fkey_reg;
    assign res.dropped         = dropped_reg;
    assign res.fill_level      = FILL_W'(count_reg);

    // checks
    `ART_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `ART_ASSERT_IMPLY(a_write_in_fill, wr_en, CNT_W'(wr_addr) <= count_reg, "write past fill")
    `ART_ASSERT_NEXT(a_lookup_keeps_count, state_reg == ST_LSCAN, $stable(count_reg), "lookup changed count")
    `ART_ASSERT_IMPLY(a_done_in_idle, done_reg, state_reg == ST_IDLE, "done while sequencer busy")

endmodule

`default_nettype wire

// File: hdl/aged_request_tracker.sv
// top level of the aged request tracker: handshakes, age limit register, result register
//
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------------------
// request   | start / busy               | req_type, client_address, server_address,
//           |                            | track_key, now_seconds
// config    | cfg_valid / cfg_ready      | cfg_data (age limit)
// result    | result_valid (one cycle)   | found, found_track_key, dropped, fill_level
//
// a lookup reads the table one entry per cycle and keeps the newest matching entry
// a record checks the age of each entry, moves the last entry into an evicted slot,
// then appends the request or drops it when the table is full
// reset clears the fill count and sets the age limit to 10; the table needs no clearing
// the receiver cannot stall: each result strobe lasts exactly one cycle
`timescale 1ns / 1ps
`default_nettype none
`include "aged_request_tracker_assert.svh"

module aged_request_tracker
    import art_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              req_type,
    input  wire logic [WORD_W-1:0] client_address,
    input  wire logic [WORD_W-1:0] server_address,
    input  wire logic [WORD_W-1:0] track_key,
    input  wire logic [WORD_W-1:0] now_seconds,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [AGE_W-1:0]  cfg_data,
    output logic                   result_valid,
    output logic                   found,
    output logic [WORD_W-1:0]      found_track_key,
    output logic                   dropped,
    output logic [FILL_W-1:0]      fill_level
);

    logic [AGE_W-1:0] age_limit_reg;
    logic             result_valid_reg;
    res_t             result_reg;
    req_t             req;
    res_t             eng_res;
    logic             eng_busy;
    logic             eng_done;
    logic             accept;

    assign accept = start && !eng_busy;

    // request transaction payload
    assign req.req_type       = req_type;
    assign req.client_address = client_address;
    assign req.server_address = server_address;
    assign req.track_key      = track_key;
    assign req.now_seconds    = now_seconds;

    art_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .req       (req),
        .age_limit (age_limit_reg),
        .busy      (eng_busy),
        .done      (eng_done),
        .res       (eng_res)
    );

    // age limit register, written between requests
    assign cfg_ready = !eng_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg <= AGE_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            age_limit_reg <= cfg_data;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= eng_done;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            result_reg <= eng_res;
        end
    end

    assign busy            = eng_busy;
    assign result_valid    = result_valid_reg;
    assign found           = result_reg.found;
    assign found_track_key = result_reg.found_track_key;
    assign dropped         = result_reg.dropped;
    assign fill_level      = result_reg.fill_level;

    // checks
    `ART_ASSERT_NEXT(a_strobe_single, result_valid_reg, !result_valid_reg, "result strobe held")
    `ART_ASSERT_IMPLY(a_found_or_dropped, result_valid, !(found && dropped), "found and dropped")
    `ART_ASSERT_IMPLY(a_no_accept_at_done, eng_done, !eng_busy, "result while request in flight")

endmodule

`default_nettype wire

// File: dv/aged_request_tracker_test.sv
// self-checking testbench of the aged request tracker
`timescale 1ns / 1ps

module aged_request_tracker_test;
    import art_pkg::*;

    // one row of the directed stimulus: request, whether the result is given, that result
    typedef struct packed {
        req_t req;
        logic typed;
        res_t res;
    } dir_row_t;

    localparam int DIR_ROWS = 20;
    localparam logic T = 1'b1;
    localparam logic P = 1'b0;

    // directed requests at the reset age limit of 10
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // lookup on an empty table
        '{'{REQ_LOOKUP, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0}, T, '{1'b0, 32'h0, 1'b0, 6'd1 - 6'd1}},
        // entry stamped zero
        '{'{REQ_RECORD, 32'h1, 32'h2, 32'hAAAA_AAAA, 32'h0}, T, '{1'b0, 32'h0, 1'b0, 6'd1}},
        // a zero stamp never matches
        '{'{REQ_LOOKUP, 32'h1, 32'h2, 32'h0, 32'h0}, T, '{1'b0, 32'h0, 1'b0, 6'd1}},
        '{'{REQ_RECORD, 32'h1, 32'h2, 32'h1111_1111, 32'd5}, T, '{1'b0, 32'h0, 1'b0, 6'd2}},
        '{'{REQ_RECORD, 32'h1, 32'h2, 32'h2222_2222, 32'd5}, T, '{1'b0, 32'h0, 1'b0, 6'd3}},
        // equal stamps go to the lowest slot
        '{'{REQ_LOOKUP, 32'h1, 32'h2, 32'h0, 32'd5}, T,
            '{1'b1, 32'h1111_1111, 1'b0, 6'd3}},
        // age equal to the limit is kept
        '{'{REQ_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd10}, T,
            '{1'b0, 32'h0, 1'b0, 6'd4}},
        // slot 0 evicted, refilled from the last entry and checked again
        '{'{REQ_RECORD, 32'h3, 32'h4, 32'h3, 32'd11}, P, '0},
        '{'{REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'd11}, T,
            '{1'b1, 32'hFFFF_FFFF, 1'b0, 6'd4}},
        // everything evicted in one walk
        '{'{REQ_RECORD, 32'h5, 32'h6, 32'h5555_5555, 32'd100}, T, '{1'b0, 32'h0, 1'b0, 6'd1}},
        // time going back makes a huge modular age
        '{'{REQ_RECORD, 32'h7, 32'h8, 32'h7777_7777, 32'h0}, T, '{1'b0, 32'h0, 1'b0, 6'd1}},
        '{'{REQ_RECORD, 32'h9, 32'hA, 32'h9999_9999, 32'hFFFF_FFF8}, T,
            '{1'b0, 32'h0, 1'b0, 6'd1}},
        // age across the 32-bit wrap stays small
        '{'{REQ_RECORD, 32'h9, 32'hA, 32'h0, 32'd2}, T, '{1'b0, 32'h0, 1'b0, 6'd2}},
        '{'{REQ_LOOKUP, 32'h9, 32'hA, 32'h0, 32'd2}, P, '0},
        // only one address matches
        '{'{REQ_LOOKUP, 32'h9, 32'h0, 32'h0, 32'd2}, T, '{1'b0, 32'h0, 1'b0, 6'd2}},
        '{'{REQ_LOOKUP, 32'h0, 32'hA, 32'h0, 32'd2}, T, '{1'b0, 32'h0, 1'b0, 6'd2}},
        '{'{REQ_RECORD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5A5A_5A5A, 32'd7}, P, '0},
        '{'{REQ_RECORD, 32'hAAAA_AAAA, 32'h5555_5555, 32'hA5A5_A5A5, 32'd8}, P, '0},
        '{'{REQ_LOOKUP, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'd8}, P, '0},
        // lookup far in the future evicts nothing
        '{'{REQ_LOOKUP, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'hFFFF_FFFF}, P, '0}
    };

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              req_type = REQ_RECORD;
    logic [WORD_W-1:0] client_address = '0;
    logic [WORD_W-1:0] server_address = '0;
    logic [WORD_W-1:0] track_key = '0;
    logic [WORD_W-1:0] now_seconds = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [AGE_W-1:0]  cfg_data = '0;
    logic              result_valid;
    logic              found;
    logic [WORD_W-1:0] found_track_key;
    logic              dropped;
    logic [FILL_W-1:0] fill_level;

    // predictor state
    entry_t            entries [CAPACITY];
    int unsigned       entry_count = 0;
    logic [AGE_W-1:0]  limit_model = AGE_LIMIT_RESET;

    res_t              awaited_results [$];
    int unsigned       mismatch_count = 0;
    bit                idle_on = 1'b1;
    logic [WORD_W-1:0] client_pool [4];
    logic [WORD_W-1:0] server_pool [4];

    aged_request_tracker dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .client_address(client_address),
        .server_address(server_address),
        .track_key(track_key),
        .now_seconds(now_seconds),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .found(found),
        .found_track_key(found_track_key),
        .dropped(dropped),
        .fill_level(fill_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("aged_request_tracker_test: FAIL");
        $finish;
    end

    // age out, then append or drop; or find the newest matching entry
    function automatic res_t track_request(input req_t r);
        res_t        res;
        int unsigned slot;
        logic [31:0] age;
        logic [31:0] best;
        res = '0;
        if (r.req_type == REQ_RECORD)
        begin
            slot = 0;
            while (slot < entry_count)
            begin
                age = r.now_seconds - entries[slot].stamp;
                if (age > {24'd0, limit_model})
                begin
                    entry_count--;
                    entries[slot] = entries[entry_count];
                end
                else
                begin
                    slot++;
                end
            end
            if (entry_count < CAPACITY)
            begin
                entries[entry_count] = '{r.client_address, r.server_address, r.track_key,
                                         r.now_seconds};
                entry_count++;
            end
            else
            begin
                res.dropped = 1'b1;
            end
        end
        else
        begin
            best = '0;
            for (slot = 0; slot < entry_count; slot++)
            begin
                if (entries[slot].client == r.client_address &&
                    entries[slot].server == r.server_address &&
                    entries[slot].stamp > best)
                begin
                    best = entries[slot].stamp;
                    res.found = 1'b1;
                    res.found_track_key = entries[slot].key;
                end
            end
        end
        res.fill_level = FILL_W'(entry_count);
        return res;
    endfunction

    task automatic note_failure(input string what, input res_t want, input res_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: want found=%0b key=%h dropped=%0b fill=%0d, got found=%0b key=%h dropped=%0b fill=%0d",
                     what, want.found, want.found_track_key, want.dropped, want.fill_level,
                     got.found, got.found_track_key, got.dropped, got.fill_level);
    endtask

    // present one request, with random idle cycles before it; returns at the accepting edge
    task automatic send_request(input req_t r, input logic typed, input res_t given);
        res_t predicted;
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 25)
        begin
            start <= 1'b0;
            client_address <= $urandom;
            track_key <= $urandom;
            @(negedge clk);
        end
        start <= 1'b1;
        req_type <= r.req_type;
        client_address <= r.client_address;
        server_address <= r.server_address;
        track_key <= r.track_key;
        now_seconds <= r.now_seconds;
        do @(posedge clk); while (busy);
        predicted = track_request(r);
        awaited_results.push_back(typed ? given : predicted);
    endtask

    // stop issuing and wait for every outstanding result
    task automatic drain_results;
        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_age_limit(input logic [AGE_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        limit_model = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data <= $urandom;
    endtask

    // random requests over a small address pool with a mostly advancing clock
    task automatic run_phase(input logic [AGE_W-1:0] limit, input int count,
                             input int step_max, input bit with_idle,
                             input logic [WORD_W-1:0] first_now);
        req_t              r;
        logic [WORD_W-1:0] now_s;
        int                roll;
        write_age_limit(limit);
        idle_on = with_idle;
        now_s = first_now;
        foreach (client_pool[k])
        begin
            client_pool[k] = $urandom;
            server_pool[k] = $urandom;
        end
        for (int n = 0; n < count; n++)
        begin
            r.req_type = ($urandom_range(99) < 60) ? REQ_RECORD : REQ_LOOKUP;
            r.client_address = ($urandom_range(9) == 0) ? $urandom
                                                        : client_pool[$urandom_range(3)];
            r.server_address = ($urandom_range(9) == 0) ? $urandom
                                                        : server_pool[$urandom_range(3)];
            r.track_key = $urandom;
            roll = $urandom_range(99);
            if (roll < 2)
                now_s = $urandom;
            else if (roll < 5)
                now_s = now_s - $urandom_range(20);
            else
                now_s = now_s + $urandom_range(step_max);
            r.now_seconds = now_s;
            send_request(r, 1'b0, '0);
        end
        idle_on = 1'b1;
    endtask

    // compare each result strobe with the oldest awaited result
    always @(posedge clk)
    begin : check_results
        res_t want;
        res_t got;
        if (rst_n && result_valid)
        begin
            got = '{found, found_track_key, dropped, fill_level};
            if (awaited_results.size() == 0)
            begin
                note_failure("unexpected result", '0, got);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.found !== want.found || got.found_track_key !== want.found_track_key ||
                    got.dropped !== want.dropped || got.fill_level !== want.fill_level)
                    note_failure("result mismatch", want, got);
            end
        end
    end

    // stimulus sequence
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].res);

        // long limit fills the table and drops, zero limit evicts on any nonzero age
        run_phase(8'd255, 130, 2, 1'b1, $urandom);
        run_phase(8'd0, 100, 1, 1'b1, $urandom);
        run_phase(AGE_W'($urandom_range(255)), 110, 4, 1'b0, $urandom);
        // clock crossing the 32-bit wrap, stamps of zero included
        run_phase(8'd1, 90, 1, 1'b1, 32'hFFFF_FFE0);
        run_phase(AGE_LIMIT_RESET, 100, 3, 1'b1, $urandom);
        run_phase(AGE_W'($urandom_range(255)), 120, 8, 1'b1, $urandom);

        drain_results();
        repeat (120) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            mismatch_count += awaited_results.size();
            $display("%0d results never arrived", awaited_results.size());
        end
        if (mismatch_count == 0)
            $display("aged_request_tracker_test: PASS");
        else
            $display("aged_request_tracker_test: FAIL");
        $finish;
    end

endmodule
